/* design/indexed_array_list_core_assert.svh */
// assertion macros for the indexed array list core
`ifndef INDEXED_ARRAY_LIST_CORE_ASSERT_SVH
`define INDEXED_ARRAY_LIST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during rst
`define IAL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("indexed array list assertion failed");
// next-cycle implication, sampled on clk, off during rst
`define IAL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("indexed array list assertion failed");
`else
`define IAL_ASSERT_IMP(label, ante, cons)
`define IAL_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* design/ial_pkg.sv */
// shared types and constants for the indexed array list core
`default_nettype none
package ial_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CMD_W      = 2;
  localparam int POS_W      = 5;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_GET    = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_find;
    logic scan_done;
  } dp_status_t;

endpackage
`default_nettype wire

/* design/ial_ctrl.sv */
// controller state machine for the indexed array list core
`default_nettype none
module ial_ctrl
  import ial_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t dp_status,
  output ctrl_cmd_t  ctrl_cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl_cmd   = '0;
    busy       = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl_cmd.load = 1'b1;
          state_next    = dp_status.req_find ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl_cmd.exec = 1'b1;
        state_next    = S_IDLE;
      end
      S_SCAN: begin
        ctrl_cmd.scan = 1'b1;
        if (dp_status.scan_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/ial_datapath.sv */
// entry registers, count, scan pointer and result registers
`default_nettype none
module ial_datapath
  import ial_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_cmd_t                 ctrl_cmd,
  output dp_status_t                dp_status,
  input  logic [CMD_W-1:0]          cmd,
  input  logic [POS_W-1:0]          position,
  input  logic [VALUE_W-1:0]        value,
  output logic                      done,
  output logic [VALUE_W-1:0]        read_data,
  output logic signed [POS_W-1:0]   found_position,
  output logic [STATUS_W-1:0]       status,
  output logic [POS_W-1:0]          size
);

  logic [DATA_WIDTH-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  cmd_t                  op;
  logic [POS_W-1:0]      pos;
  logic [DATA_WIDTH-1:0] val;
  logic [CNT_W-1:0]      idx;

  logic                  pos_gt_count;
  logic                  pos_ge_count;
  logic                  full;
  logic                  ins_ok;
  logic                  ers_ok;
  logic                  get_ok;
  logic [IDX_W-1:0]      pidx;
  logic                  scan_end;
  logic                  scan_hit;
  status_t               exec_status;

  assign dp_status.req_find  = (cmd_t'(cmd) == CMD_FIND);
  assign dp_status.scan_done = scan_hit | scan_end;

  assign pos_gt_count = CMP_W'(pos) > CMP_W'(count);
  assign pos_ge_count = CMP_W'(pos) >= CMP_W'(count);
  assign full         = count >= CNT_W'(CAPACITY);
  assign ins_ok       = (op == CMD_INSERT) && !pos_gt_count && !full;
  assign ers_ok       = (op == CMD_ERASE) && !pos_ge_count;
  assign get_ok       = (op == CMD_GET) && !pos_ge_count;
  assign pidx         = pos[IDX_W-1:0];

  // scan walks one entry a cycle from position zero
  assign scan_end = !(idx < count);
  assign scan_hit = !scan_end && (entries[idx[IDX_W-1:0]] == val);

  always_comb begin
    count_next  = count;
    exec_status = ST_OK;
    unique case (op)
      CMD_INSERT: begin
        if (pos_gt_count) begin
          exec_status = ST_BAD_POS;
        end else if (full) begin
          exec_status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      CMD_ERASE: begin
        if (pos_ge_count) begin
          exec_status = ST_BAD_POS;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      CMD_GET: begin
        if (pos_ge_count) begin
          exec_status = ST_BAD_POS;
        end
      end
      CMD_FIND: begin
        exec_status = ST_NOT_FOUND;
      end
      default: begin
        exec_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (ctrl_cmd.exec) || (ctrl_cmd.scan && dp_status.scan_done);
      if (ctrl_cmd.exec) begin
        count <= count_next;
      end
    end
  end

  // command latch and scan pointer
  always_ff @(posedge clk) begin
    if (ctrl_cmd.load) begin
      op  <= cmd_t'(cmd);
      pos <= position;
      val <= value[DATA_WIDTH-1:0];
      idx <= '0;
    end else if (ctrl_cmd.scan && !dp_status.scan_done) begin
      idx <= idx + CNT_W'(1);
    end
  end

  // parallel shift on insert and erase
  always_ff @(posedge clk) begin
    if (ctrl_cmd.exec && ins_ok) begin
      if (pidx == IDX_W'(0)) begin
        entries[0] <= val;
      end
      for (int k = 1; k < CAPACITY; k++) begin
        if (CMP_W'(k) > CMP_W'(pos)) begin
          entries[k] <= entries[k-1];
        end else if (CMP_W'(k) == CMP_W'(pos)) begin
          entries[k] <= val;
        end
      end
    end else if (ctrl_cmd.exec && ers_ok) begin
      for (int k = 0; k < CAPACITY - 1; k++) begin
        if (CMP_W'(k) >= CMP_W'(pos)) begin
          entries[k] <= entries[k+1];
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (ctrl_cmd.exec) begin
      read_data      <= get_ok ? VALUE_W'(entries[pidx]) : '0;
      found_position <= '1;
      status         <= exec_status;
      size           <= POS_W'(count_next);
    end else if (ctrl_cmd.scan && dp_status.scan_done) begin
      read_data      <= '0;
      found_position <= scan_hit ? POS_W'(idx) : '1;
      status         <= scan_hit ? ST_OK : ST_NOT_FOUND;
      size           <= POS_W'(count);
    end
  end

endmodule
`default_nettype wire

/* design/indexed_array_list_core.sv */
// top level of the indexed array list core: controller plus datapath
// insert, erase and get: word taken at a start edge, run in the execute state, then a registered result strobe
// find: scans one entry a cycle from position zero until a match or the list end, then strobes
// a new word is taken only once the last one is through; busy low in the strobe cycle
// done is a single-cycle strobe; the receiver cannot stall, so results are never held
// rst (synchronous) empties the list; entry contents stay undefined until written
`default_nettype none
`include "indexed_array_list_core_assert.svh"
module indexed_array_list_core
  import ial_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [CMD_W-1:0]          cmd,
  input  logic [POS_W-1:0]          position,
  input  logic [VALUE_W-1:0]        value,
  output logic                      done,
  output logic [VALUE_W-1:0]        read_data,
  output logic signed [POS_W-1:0]   found_position,
  output logic [STATUS_W-1:0]       status,
  output logic [POS_W-1:0]          size
);

  // command and status between controller and datapath
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // sequencer: idle, an execute state, or a find scan
  ial_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .dp_status (dp_status),
    .ctrl_cmd  (ctrl_cmd),
    .busy      (busy)
  );

  // entry registers, shifting, scan compare and the result word
  ial_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl_cmd       (ctrl_cmd),
    .dp_status      (dp_status),
    .cmd            (cmd),
    .position       (position),
    .value          (value),
    .done           (done),
    .read_data      (read_data),
    .found_position (found_position),
    .status         (status),
    .size           (size)
  );

  // an accepted word always makes the block busy on the next cycle
  `IAL_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // two results never come back to back
  `IAL_ASSERT_NXT(a_no_double_done, done, !done)
  // the list never reports more than it can hold
  `IAL_ASSERT_IMP(a_size_cap, done, size <= POS_W'(CAPACITY))
  // a missed find carries no position
  `IAL_ASSERT_IMP(a_miss_pos, done && (status == ST_NOT_FOUND), found_position == '1)

endmodule
`default_nettype wire

/* verif/array_list_checker.sv */
`timescale 1ns / 100ps
// checker for the indexed array list core: list predictor and result compare
module array_list_checker
  import ial_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [CMD_W-1:0]        cmd,
  input  logic [POS_W-1:0]        position,
  input  logic [VALUE_W-1:0]      value,
  input  logic                    done,
  input  logic [VALUE_W-1:0]      read_data,
  input  logic signed [POS_W-1:0] found_position,
  input  logic [STATUS_W-1:0]     status,
  input  logic [POS_W-1:0]        size,
  output int                      mismatches,
  output int                      outstanding,
  output int                      results_checked
);

  localparam logic [POS_W-1:0] NO_MATCH = '1;

  typedef struct packed {
    logic [VALUE_W-1:0] read_data;
    logic [POS_W-1:0]   found;
    status_t            status;
    logic [POS_W-1:0]   new_size;
  } list_result_t;

  // shadow copy of the list
  logic [DATA_WIDTH-1:0] stored [CAPACITY];
  int                    fill;
  list_result_t          expected_q [$];

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
    fill            = 0;
  end

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // applies one command to the shadow list and returns its result word
  function automatic list_result_t apply_command(cmd_t op, int p,
                                                 logic [VALUE_W-1:0] val);
    list_result_t          r;
    logic [DATA_WIDTH-1:0] key;
    logic                  hit;
    int                    k;
    r.read_data = '0;
    r.found     = NO_MATCH;
    r.status    = ST_OK;
    key         = val[DATA_WIDTH-1:0];
    hit         = 1'b0;
    case (op)
      CMD_INSERT: begin
        // past-the-end check wins over the full check
        if (p > fill) r.status = ST_BAD_POS;
        else if (fill >= CAPACITY) r.status = ST_FULL;
        else begin
          for (k = fill; k > p; k--) stored[k] = stored[k-1];
          stored[p] = key;
          fill++;
        end
      end
      CMD_ERASE: begin
        if (p >= fill) r.status = ST_BAD_POS;
        else begin
          for (k = p; k + 1 < fill; k++) stored[k] = stored[k+1];
          fill--;
          stored[fill] = '0;
        end
      end
      CMD_GET: begin
        if (p >= fill) r.status = ST_BAD_POS;
        else r.read_data = VALUE_W'(stored[p]);
      end
      default: begin
        r.status = ST_NOT_FOUND;
        for (k = 0; k < fill; k++) begin
          if (!hit && stored[k] == key) begin
            hit      = 1'b1;
            r.found  = POS_W'(k);
            r.status = ST_OK;
          end
        end
      end
    endcase
    r.new_size = POS_W'(fill);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      fill = 0;
      for (int k = 0; k < CAPACITY; k++) stored[k] = '0;
      expected_q.delete();
    end else begin
      // result first: a word accepted on this edge answers later
      if (done) begin
        if (expected_q.size() == 0) begin
          flag_mismatch("result strobe with no command outstanding");
        end else begin
          want = expected_q.pop_front();
          results_checked++;
          if (read_data !== want.read_data)
            flag_mismatch($sformatf("read_data got %h expected %h",
                                    read_data, want.read_data));
          if (found_position !== want.found)
            flag_mismatch($sformatf("found_position got %0d expected %0d",
                                    found_position, $signed(want.found)));
          if (status !== want.status)
            flag_mismatch($sformatf("status got %0d expected %0d",
                                    status, want.status));
          if (size !== want.new_size)
            flag_mismatch($sformatf("size got %0d expected %0d",
                                    size, want.new_size));
        end
      end
      if (start && !busy)
        expected_q.push_back(apply_command(cmd_t'(cmd), int'(position), value));
    end
    outstanding = expected_q.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// top testbench for the indexed array list core: clock, reset, command stimulus, verdict
module tb;
  import ial_pkg::*;

  localparam int RANDOM_WORDS = 1200;
  localparam int STALL_LIMIT  = 400;   // cycles with no word moving at all

  logic                    clk;
  logic                    rst      = 1'b1;
  logic                    start    = 1'b0;
  logic                    busy;
  logic [CMD_W-1:0]        cmd      = CMD_INSERT;
  logic [POS_W-1:0]        position = '0;
  logic [VALUE_W-1:0]      value    = '0;
  logic                    done;
  logic [VALUE_W-1:0]      read_data;
  logic signed [POS_W-1:0] found_position;
  logic [STATUS_W-1:0]     status;
  logic [POS_W-1:0]        size;

  int mismatches;
  int outstanding;
  int results_checked;

  // stimulus bookkeeping: list length as the sender sees it, for steering only
  int list_len    = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int n_insert    = 0;
  int n_erase     = 0;
  int n_get       = 0;
  int n_find      = 0;
  int full_visits = 0;
  logic               growing = 1'b1;
  logic [VALUE_W-1:0] recent [8];

  indexed_array_list_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .position      (position),
    .value         (value),
    .done          (done),
    .read_data     (read_data),
    .found_position(found_position),
    .status        (status),
    .size          (size)
  );

  array_list_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .position       (position),
    .value          (value),
    .done           (done),
    .read_data      (read_data),
    .found_position (found_position),
    .status         (status),
    .size           (size),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_checked(results_checked)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: ends the run when neither a command nor a result moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // drives one command word and holds it until the core takes it
  task automatic send_word(cmd_t op, int pos, logic [VALUE_W-1:0] val);
    start    <= 1'b1;
    cmd      <= op;
    position <= POS_W'(pos);
    value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    // word taken on this edge: follow the list length for steering
    case (op)
      CMD_INSERT: begin
        n_insert++;
        if (pos <= list_len && list_len < CAPACITY) begin
          list_len++;
          if (list_len == CAPACITY) full_visits++;
          recent[$urandom_range(0, 7)] = val;
        end
      end
      CMD_ERASE: begin
        n_erase++;
        if (pos < list_len) list_len--;
      end
      CMD_GET:   n_get++;
      default:   n_find++;
    endcase
  endtask

  // sender pacing: bursts of back-to-back words, then a random gap
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic issue(cmd_t op, int pos, logic [VALUE_W-1:0] val);
    send_word(op, pos, val);
    pace();
  endtask

  // data word mix: full-range, extremes, a few small repeats, recent inserts
  function automatic logic [VALUE_W-1:0] pick_value(logic lookup);
    int r;
    r = $urandom_range(0, 99);
    if (lookup && r < 60) return recent[$urandom_range(0, 7)];
    if (r < 40) return $urandom;
    if (r < 55) return '0;
    if (r < 70) return '1;
    if (r < 85) return VALUE_W'($urandom_range(0, 7));
    return recent[$urandom_range(0, 7)];
  endfunction

  initial begin : stimulus
    int   r;
    int   pos;
    cmd_t op;
    for (int k = 0; k < 8; k++) recent[k] = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: commands against an empty list
    issue(CMD_GET,    0, '0);
    issue(CMD_ERASE,  0, '0);
    issue(CMD_FIND,   0, '0);
    issue(CMD_INSERT, 1, 32'h0BAD_0001);       // past the end
    // build up front, back and middle
    issue(CMD_INSERT, 0, '0);
    issue(CMD_INSERT, 1, '1);
    issue(CMD_INSERT, 1, 32'hA5A5_A5A5);
    // fill to capacity at the tail, with a repeat of the all-ones word
    for (int i = 0; i < CAPACITY - 3; i++) begin
      if (i == CAPACITY - 4)   issue(CMD_INSERT, list_len, 32'hC3C3_5A5A);
      else if (i == 5)         issue(CMD_INSERT, list_len, '1);
      else                     issue(CMD_INSERT, list_len, 32'h1000_0000 + i);
    end
    issue(CMD_INSERT, 0, 32'hDEAD_BEEF);       // list full
    issue(CMD_INSERT, CAPACITY, 32'hDEAD_BEEF);
    issue(CMD_FIND,   0, '1);                  // lowest of two matches
    issue(CMD_GET,    CAPACITY - 1, '0);
    issue(CMD_GET,    CAPACITY, '0);           // one past the end
    issue(CMD_FIND,   0, 32'hC3C3_5A5A);       // match in the last slot
    issue(CMD_ERASE,  CAPACITY - 1, '0);
    issue(CMD_ERASE,  0, '0);
    issue(CMD_FIND,   0, 32'h1234_5678);       // absent

    // random: phases that grow toward full and shrink toward empty
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (list_len == CAPACITY) growing = 1'b0;
      else if (list_len == 0) growing = 1'b1;
      else if ($urandom_range(0, 49) == 0) growing = ~growing;
      r = $urandom_range(0, 99);
      if (r < 15)      op = CMD_GET;
      else if (r < 30) op = CMD_FIND;
      else if (r < 45) op = growing ? CMD_ERASE : CMD_INSERT;
      else             op = growing ? CMD_INSERT : CMD_ERASE;
      // mostly within the list length, sometimes anywhere from zero to capacity
      if ($urandom_range(0, 99) < 85) pos = $urandom_range(0, list_len);
      else pos = $urandom_range(0, CAPACITY);
      issue(op, pos, pick_value(op == CMD_FIND));
    end

    // drain: let every outstanding result arrive, then the longest scan
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (CAPACITY + 4) @(posedge clk);

    $display("covered %0d inserts, %0d erases, %0d gets, %0d finds",
             n_insert, n_erase, n_get, n_find);
    $display("list reached capacity %0d times; %0d results compared",
             full_visits, results_checked);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
